// File: rtl/core/address_to_function_line_lookup_top_macros.svh
// Assertion macros for the address-to-function-and-line lookup block.
// Depends on nothing; the user provides clk_i and rst_ni in scope.
`ifndef ADDRESS_TO_FUNCTION_LINE_LOOKUP_TOP_MACROS_SVH
`define ADDRESS_TO_FUNCTION_LINE_LOOKUP_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define AFL_ASSERT_IMPLY(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);
`define AFL_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define AFL_ASSERT_IMPLY(lbl, pre, post, msg)
`define AFL_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// File: rtl/core/afl_pkg.sv
// Types and codes shared by the address-to-function-and-line lookup block.
// Depends on nothing.
`default_nettype none
package afl_pkg;

  typedef enum logic [1:0] {
    OP_FUNC_WR = 2'd0,
    OP_LINE_WR = 2'd1,
    OP_LOOKUP  = 2'd2
  } op_e;

  localparam logic CFG_FUNCTION_COUNT = 1'b0;
  localparam logic CFG_LINE_COUNT     = 1'b1;
  localparam int unsigned CFG_W = 13;

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] slot;
    logic [31:0] address;
    logic [31:0] range_length;
    logic [31:0] file_base;
    logic [11:0] first_line;
    logic [15:0] line_value;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [9:0]  function_position;
    logic [15:0] source_line;
  } out_item_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
    logic [31:0] file_base;
    logic [11:0] first_line;
  } func_entry_t;

  typedef struct packed {
    logic [31:0] offset;
    logic [15:0] number;
  } line_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LO_CHK,
    S_HI_CHK,
    S_MID_CHK,
    S_W_START,
    S_W_CUR,
    S_W_NXT,
    S_DONE
  } state_e;

endpackage
`default_nettype wire

// File: rtl/core/address_to_function_line_lookup_top.sv
// A lookup runs a binary search over the function table, checking the low bound, the high
// bound and the midpoint in turn, then walks the line table from first_line and finishes.
// Each probe and step waits on the registered read data of the function and line RAMs.
// Table writes and unused ops answer with an all-zero result. Reset clears the counts and control,
// not the tables; there is no clearing pass.
`default_nettype none
`include "address_to_function_line_lookup_top_macros.svh"
module address_to_function_line_lookup_top
  import afl_pkg::*;
#(
  parameter int unsigned FUNC_DEPTH = 1024,
  parameter int unsigned LINE_DEPTH = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_item_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_data_o
);

  localparam int unsigned FW = $clog2(FUNC_DEPTH);
  localparam int unsigned LW = $clog2(LINE_DEPTH);
  localparam int unsigned IW = (LW + 1 > 12) ? LW + 1 : 12;

  logic [10:0] func_count_q;
  logic [12:0] line_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      func_count_q <= '0;
      line_count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FUNCTION_COUNT: func_count_q <= cfg_data_i[10:0];
        CFG_LINE_COUNT:     line_count_q <= cfg_data_i;
        default:            ;
      endcase
    end
  end

  state_e      state_q, state_d;
  logic [FW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d, pos_q, pos_d;
  logic [31:0] addr_q, addr_d, base_q, base_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [15:0] cur_line_q, cur_line_d;
  out_item_t   res_q, res_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_data_q, out_data_d;

  logic        func_we, line_we;
  logic [FW-1:0] func_raddr;
  logic [LW-1:0] line_raddr;
  func_entry_t func_wdata, func_rdata;
  line_entry_t line_wdata, line_rdata;
  logic [31:0] slot_ext;

  logic [FW:0]   nf;
  logic [LW:0]   nl;
  logic [FW:0]   mid_sum;
  logic [FW-1:0] mid_c;
  logic [31:0]   func_end;
  logic          covers;
  logic [IW:0]   idx_inc;
  logic [31:0]   idx_ext, idx_inc_ext, pos_ext, line_here;
  logic          out_free, in_xfer;

  assign slot_ext   = 32'(in_data_i.slot);
  assign func_wdata = '{start: in_data_i.address, length: in_data_i.range_length,
                        file_base: in_data_i.file_base, first_line: in_data_i.first_line};
  assign line_wdata = '{offset: in_data_i.address, number: in_data_i.line_value};

  afl_ram #(.DEPTH(FUNC_DEPTH), .WIDTH($bits(func_entry_t))) u_func_ram (
    .clk_i   (clk_i),
    .we_i    (func_we),
    .waddr_i (slot_ext[FW-1:0]),
    .wdata_i (func_wdata),
    .raddr_i (func_raddr),
    .rdata_o (func_rdata)
  );

  afl_ram #(.DEPTH(LINE_DEPTH), .WIDTH($bits(line_entry_t))) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (slot_ext[LW-1:0]),
    .wdata_i (line_wdata),
    .raddr_i (line_raddr),
    .rdata_o (line_rdata)
  );

  assign nf = (32'(func_count_q) > FUNC_DEPTH) ? (FW+1)'(FUNC_DEPTH) : (FW+1)'(func_count_q);
  assign nl = (32'(line_count_q) > LINE_DEPTH) ? (LW+1)'(LINE_DEPTH) : (LW+1)'(line_count_q);
  assign mid_sum     = (FW+1)'(lo_q) + (FW+1)'(hi_q);
  assign mid_c       = mid_sum[FW:1];
  assign func_end    = func_rdata.start + func_rdata.length;
  assign covers      = (func_rdata.start <= addr_q) && (addr_q < func_end);
  assign idx_inc     = {1'b0, idx_q} + (IW+1)'(1);
  assign idx_ext     = 32'(idx_q);
  assign idx_inc_ext = 32'(idx_inc);
  assign pos_ext     = 32'(pos_q);
  assign line_here   = line_rdata.offset + base_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE) && out_free;
  assign in_xfer     = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    pos_d       = pos_q;
    addr_d      = addr_q;
    base_d      = base_q;
    idx_d       = idx_q;
    cur_line_d  = cur_line_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    func_we     = 1'b0;
    line_we     = 1'b0;
    func_raddr  = lo_q;
    line_raddr  = idx_ext[LW-1:0];
    unique case (state_q)
      S_IDLE: begin
        func_raddr = '0;
        if (in_xfer) begin
          if (in_data_i.op == OP_LOOKUP) begin
            addr_d = in_data_i.address;
            lo_d   = '0;
            hi_d   = FW'(nf - (FW+1)'(1));
            res_d  = '0;
            if (nf == '0) begin
              state_d = S_DONE;
            end else begin
              state_d = S_LO_CHK;
            end
          end else begin
            func_we     = (in_data_i.op == OP_FUNC_WR) && (slot_ext < FUNC_DEPTH);
            line_we     = (in_data_i.op == OP_LINE_WR) && (slot_ext < LINE_DEPTH);
            out_valid_d = 1'b1;
            out_data_d  = '0;
          end
        end
      end
      S_LO_CHK, S_HI_CHK: begin
        func_raddr = (state_q == S_LO_CHK) ? hi_q : mid_c;
        mid_d      = mid_c;
        if (covers) begin
          pos_d   = (state_q == S_LO_CHK) ? lo_q : hi_q;
          base_d  = func_rdata.file_base;
          idx_d   = IW'(func_rdata.first_line);
          state_d = S_W_START;
        end else if (state_q == S_LO_CHK) begin
          state_d = S_HI_CHK;
        end else if (mid_c == lo_q || mid_c == hi_q) begin
          state_d = S_DONE;
        end else begin
          state_d = S_MID_CHK;
        end
      end
      S_MID_CHK: begin
        if (addr_q < func_rdata.start) begin
          hi_d       = mid_q;
          func_raddr = lo_q;
        end else begin
          lo_d       = mid_q;
          func_raddr = mid_q;
        end
        state_d = S_LO_CHK;
      end
      S_W_START: begin
        res_d = '{found: 1'b1, function_position: pos_ext[9:0], source_line: 16'd0};
        if (idx_inc >= (IW+1)'(nl)) begin
          state_d = S_DONE;
        end else begin
          state_d = S_W_CUR;
        end
      end
      S_W_CUR: begin
        line_raddr = idx_inc_ext[LW-1:0];
        if (addr_q < line_here) begin
          state_d = S_DONE;
        end else if (line_rdata.offset == addr_q) begin
          res_d.source_line = line_rdata.number;
          state_d           = S_DONE;
        end else begin
          cur_line_d = line_rdata.number;
          state_d    = S_W_NXT;
        end
      end
      S_W_NXT: begin
        if (addr_q < line_here) begin
          res_d.source_line = cur_line_q;
          state_d           = S_DONE;
        end else begin
          idx_d   = idx_inc[IW-1:0];
          state_d = S_W_START;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mid_q      <= mid_d;
    pos_q      <= pos_d;
    addr_q     <= addr_d;
    base_q     <= base_d;
    idx_q      <= idx_d;
    cur_line_q <= cur_line_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `AFL_ASSERT_NEXT(a_write_result, in_xfer && (in_data_i.op != OP_LOOKUP), out_valid_o, "Write transfer gave no result.")
  `AFL_ASSERT_IMPLY(a_not_found_zero, out_valid_o && !out_data_o.found, (out_data_o.function_position == '0) && (out_data_o.source_line == '0), "Miss carries nonzero fields.")
  `AFL_ASSERT_IMPLY(a_bounds_order, (state_q == S_LO_CHK) || (state_q == S_HI_CHK) || (state_q == S_MID_CHK), lo_q <= hi_q, "Search bounds crossed.")

endmodule
`default_nettype wire

// File: rtl/core/afl_ram.sv
// Simple dual-port synchronous RAM with registered read data.
// Depends on nothing.
`default_nettype none
module afl_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// File: dv/tb_address_to_function_line_lookup_top.sv
// Self-checking testbench for the address-to-function-and-line lookup block.
// Depends on afl_pkg and address_to_function_line_lookup_top; a scoreboard
// class predicts every result and the top module drives stimulus and checks it.
`default_nettype none
module tb_address_to_function_line_lookup_top;
  import afl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NFUNC = 1024;
  localparam int unsigned NLINE = 4096;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT = 100000;

  class lookup_scoreboard;
    bit [31:0] f_start [NFUNC];
    bit [31:0] f_len [NFUNC];
    bit [31:0] f_base [NFUNC];
    bit [11:0] f_first [NFUNC];
    bit        f_ok [NFUNC];
    bit [31:0] l_off [NLINE];
    bit [15:0] l_num [NLINE];
    bit        l_ok [NLINE];
    int unsigned fcnt, lcnt;
    out_item_t expected_q[$];
    int errors, lookups, hits, lines_hit;

    function void set_reg(logic idx, int unsigned v);
      if (idx == CFG_FUNCTION_COUNT) fcnt = v & 32'h7ff;
      else lcnt = v & 32'h1fff;
    endfunction

    function bit covers(int unsigned p, bit [31:0] a, inout bit clean);
      bit [31:0] e;
      clean &= f_ok[p];
      e = f_start[p] + f_len[p];
      return f_start[p] <= a && a < e;
    endfunction

    function bit [15:0] walk(int unsigned p, bit [31:0] a, inout bit clean);
      int unsigned n, i;
      bit [31:0] base;
      n = lcnt > NLINE ? NLINE : lcnt;
      base = f_base[p];
      for (i = f_first[p]; i + 1 < n; i++) begin
        clean &= l_ok[i];
        if (a < l_off[i] + base) return '0;
        if (l_off[i] == a) return l_num[i];
        clean &= l_ok[i + 1];
        if (a < l_off[i + 1] + base) return l_num[i];
      end
      return '0;
    endfunction

    // Clean is cleared when the lookup would read a table entry never written.
    function out_item_t predict(in_item_t it, output bit clean);
      out_item_t r;
      int unsigned n, lo, hi, mid, p;
      bit hit;
      r = '0;
      clean = 1;
      hit = 0;
      if (it.op != OP_LOOKUP) return r;
      n = fcnt > NFUNC ? NFUNC : fcnt;
      if (n == 0) return r;
      lo = 0;
      hi = n - 1;
      forever begin
        if (covers(lo, it.address, clean)) begin p = lo; hit = 1; break; end
        if (covers(hi, it.address, clean)) begin p = hi; hit = 1; break; end
        mid = (lo + hi) / 2;
        if (mid == lo || mid == hi) break;
        clean &= f_ok[mid];
        if (it.address < f_start[mid]) hi = mid;
        else lo = mid;
      end
      if (hit) begin
        r.found = 1'b1;
        r.function_position = p[9:0];
        r.source_line = walk(p, it.address, clean);
      end
      return r;
    endfunction

    function void note_transfer(in_item_t it);
      bit clean;
      out_item_t r;
      r = predict(it, clean);
      expected_q.push_back(r);
      if (it.op == OP_LOOKUP) begin
        lookups++;
        if (r.found) hits++;
        if (r.source_line != 0) lines_hit++;
      end
      if (it.op == OP_FUNC_WR && it.slot < NFUNC) begin
        f_start[it.slot] = it.address;
        f_len[it.slot] = it.range_length;
        f_base[it.slot] = it.file_base;
        f_first[it.slot] = it.first_line;
        f_ok[it.slot] = 1;
      end else if (it.op == OP_LINE_WR) begin
        l_off[it.slot] = it.address;
        l_num[it.slot] = it.line_value;
        l_ok[it.slot] = 1;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.found !== e.found) begin
        $display("%0t: found expected %0d actual %0d", $time, e.found, got.found);
        errors++;
      end
      if (got.function_position !== e.function_position) begin
        $display("%0t: function_position expected %0d actual %0d", $time,
                 e.function_position, got.function_position);
        errors++;
      end
      if (got.source_line !== e.source_line) begin
        $display("%0t: source_line expected %0d actual %0d", $time,
                 e.source_line, got.source_line);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_we, cfg_idx;
  logic [CFG_W-1:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  in_item_t in_data;
  out_item_t out_data;
  lookup_scoreboard sb;
  int unsigned idle_cycles;
  int unsigned out_hold;
  bit no_gaps;
  bit [31:0] nf_written, nl_written;

  address_to_function_line_lookup_top u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold--;
    end else begin
      out_ready <= 1'b1;
      out_hold = pick_gap();
    end
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic send(in_item_t it);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_transfer(it);
  endtask

  task automatic write_reg(logic idx, int unsigned v);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= v[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_counts(int unsigned nf, int unsigned nl);
    write_reg(CFG_FUNCTION_COUNT, nf);
    write_reg(CFG_LINE_COUNT, nl);
    sb.set_reg(CFG_FUNCTION_COUNT, nf);
    sb.set_reg(CFG_LINE_COUNT, nl);
  endtask

  task automatic func_wr(int unsigned slot, bit [31:0] start, bit [31:0] len,
                         bit [31:0] base, int unsigned first);
    in_item_t it;
    it = '0;
    it.op = OP_FUNC_WR;
    it.slot = 12'(slot);
    it.address = start;
    it.range_length = len;
    it.file_base = base;
    it.first_line = 12'(first);
    it.line_value = 16'($urandom);
    send(it);
  endtask

  task automatic line_wr(int unsigned slot, bit [31:0] off, bit [15:0] num);
    in_item_t it;
    it = '0;
    it.op = OP_LINE_WR;
    it.slot = 12'(slot);
    it.address = off;
    it.line_value = num;
    it.range_length = $urandom;
    send(it);
  endtask

  task automatic lookup(bit [31:0] a);
    in_item_t it;
    it = '0;
    it.op = OP_LOOKUP;
    it.address = a;
    send(it);
  endtask

  // Builds a sorted function table and a line table whose offsets rise by
  // about 16 per entry, with file bases chosen so that lookups walk them.
  task automatic build_tables(int unsigned nf, int unsigned nl);
    bit [31:0] cur, len;
    int unsigned k, fl;
    for (k = 0; k < nl; k++) line_wr(k, k * 16 + $urandom_range(0, 15), 16'($urandom));
    cur = $urandom_range(0, 32'h0fff_ffff);
    for (k = 0; k < nf; k++) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 512);
      fl = $urandom_range(0, nl > 0 ? nl - 1 : 0);
      if ($urandom_range(0, 15) == 0) fl = $urandom_range(0, 4095);
      func_wr(k, cur, len, cur - fl * 16, fl);
      cur = cur + len + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 300) : 0);
    end
    nf_written = nf;
    nl_written = nl;
  endtask

  task automatic random_items(int unsigned count);
    in_item_t it;
    out_item_t dummy;
    int unsigned k, tries, p, r;
    bit clean;
    for (k = 0; k < count; k++) begin
      tries = 0;
      do begin
        r = $urandom_range(0, 99);
        it = $bits(in_item_t)'({$urandom, $urandom, $urandom, $urandom, $urandom});
        if (r < 88) begin
          it.op = OP_LOOKUP;
          p = $urandom_range(0, nf_written > 0 ? nf_written - 1 : 0);
          if (r < 70) it.address = sb.f_start[p] + $urandom_range(0, sb.f_len[p]);
          else if (r < 80) it.address = sb.f_start[p] + sb.f_len[p] - $urandom_range(0, 2);
        end else if (r < 94) begin
          it.op = $urandom_range(0, 1) ? OP_LINE_WR : OP_UNUSED;
        end else if (r < 97) begin
          it.op = OP_FUNC_WR;
          it.slot = 12'($urandom_range(NFUNC, 4095));
        end
        dummy = sb.predict(it, clean);
        tries++;
      end while (!clean && tries < 30);
      if (!clean) it.op = OP_UNUSED;
      send(it);
    end
  endtask

  initial begin
    bit [31:0] all_ones;
    in_item_t it;
    int unsigned ph, nf, nl;
    sb = new();
    all_ones = '1;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_FUNCTION_COUNT;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    out_hold = 0;
    idle_cycles = 0;
    no_gaps = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    lookup(32'h0);
    it = '1;
    it.op = OP_UNUSED;
    send(it);
    func_wr(4095, all_ones, all_ones, all_ones, 4095);
    line_wr(4095, all_ones, 16'hffff);
    func_wr(0, 32'h0, 32'h100, 32'h100, 0);
    func_wr(1, 32'h1000, 32'h10, 32'h0, 2);
    func_wr(2, 32'hffff_fff0, 32'h20, 32'h0, 4);
    line_wr(0, 32'h0, 16'h1);
    line_wr(1, 32'h40, 16'hffff);
    line_wr(2, 32'h1000, 16'h7);
    line_wr(3, 32'h1008, 16'h9);
    line_wr(4, 32'h2000, 16'h3);
    set_counts(3, 5);
    lookup(32'h0);
    lookup(32'h100);
    lookup(32'h150);
    lookup(32'h1000);
    lookup(32'h100c);
    lookup(32'h1010);
    lookup(32'hffff_fff8);
    lookup(32'hffff_ffff);
    set_counts(2, 3);
    lookup(32'h1000);
    lookup(32'h80);

    for (ph = 0; ph < 5; ph++) begin
      no_gaps = (ph == 2);
      nf = $urandom_range(1, 30);
      nl = $urandom_range(2, 40);
      set_counts(0, 0);
      build_tables(nf, nl);
      set_counts(ph == 4 ? nf - 1 : nf, ph == 3 ? nl / 2 : nl);
      random_items(50);
    end

    no_gaps = 0;
    set_counts(nf_written, 8191);
    random_items(20);
    set_counts(nf_written, 0);
    random_items(10);

    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Ran %0d lookups: %0d found a function, %0d returned a line.",
             sb.lookups, sb.hits, sb.lines_hit);
    $display("Small sorted tables, empty counts and a saturated line count.");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: filelist.f
+incdir+rtl/core
rtl/core/afl_pkg.sv
rtl/core/afl_ram.sv
rtl/core/address_to_function_line_lookup_top.sv
dv/tb_address_to_function_line_lookup_top.sv
